// File: hdl/kpc_pkg.sv
`timescale 1ns / 1ps
package kpc_pkg;
   localparam int MaxPoints   = 1024;
   localparam int MaxClusters = 16;
   localparam int CoordWidth  = 16;
   localparam int PtIdxW      = 10;
   localparam int ClIdxW      = 4;
   localparam int CntW        = 11;
   localparam int SumW        = 27;
   localparam int DistW       = 35;

   localparam logic [1:0] ACT_LOAD    = 2'd0;
   localparam logic [1:0] ACT_RUN     = 2'd1;
   localparam logic [1:0] ACT_READ    = 2'd2;
   localparam logic [1:0] ACT_IGNORED = 2'd3;

   localparam logic [1:0] REG_K  = 2'd0;
   localparam logic [1:0] REG_IT = 2'd1;
   localparam logic [1:0] REG_N  = 2'd2;

   typedef struct packed {
      logic start;
      logic signed [SumW-1:0] dividend;
      logic [CntW-1:0] divisor;
   } div_req_type;
endpackage

// File: hdl/kpc_divider.sv
`timescale 1ns / 1ps
module kpc_divider (
   input  logic clock,
   input  logic reset,
   input  kpc_pkg::div_req_type req,
   output logic busy,
   output logic signed [kpc_pkg::CoordWidth-1:0] quotient
);
   import kpc_pkg::*;
   // restoring divide on magnitudes, one bit per cycle
   logic [SumW-1:0] rem_ff, rem_in, quo_ff, quo_in;
   logic [CntW-1:0] den_ff, den_in;
   logic [4:0] cnt_ff, cnt_in;
   logic neg_ff, neg_in, busy_ff, busy_in;
   logic [SumW:0] trial;
   logic [SumW-1:0] shifted;
   logic [SumW-1:0] qmag;

   always_comb begin
      rem_in = rem_ff; quo_in = quo_ff; den_in = den_ff; cnt_in = cnt_ff;
      neg_in = neg_ff; busy_in = busy_ff;
      shifted = '0; trial = '0;
      if (req.start) begin
         quo_in = req.dividend[SumW-1] ? SumW'(-req.dividend) : req.dividend;
         rem_in = '0; den_in = req.divisor; neg_in = req.dividend[SumW-1];
         cnt_in = 5'(SumW); busy_in = 1'b1;
      end else if (busy_ff) begin
         shifted = {rem_ff[SumW-2:0], quo_ff[SumW-1]};
         trial = {1'b0, shifted} - {{(SumW+1-CntW){1'b0}}, den_ff};
         quo_in = {quo_ff[SumW-2:0], ~trial[SumW]};
         rem_in = trial[SumW] ? shifted : trial[SumW-1:0];
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in; quo_ff <= quo_in; den_ff <= den_in; neg_ff <= neg_in;
   end

   assign qmag = neg_ff ? SumW'(-quo_ff) : quo_ff;
   assign quotient = qmag[CoordWidth-1:0];
   assign busy = busy_ff | req.start;
endmodule

// File: hdl/kmeans_point_clustering_top.sv
`timescale 1ns / 1ps
// Lloyd k-means over up to 1024 stored 3D points and up to 16 clusters. After reset the
// label store is cleared, during which requests stall. A load writes the point store
// directly; a label read goes through a memory read, then a result register, and the next
// request waits until the result transfer is taken. A run first divides N by K+1 in the
// shared serial divider, seeds K centroids (a point read and a write each), then makes
// iteration_count passes; each pass clears the sums and reads every point once,
// comparing it against the K centroids with one squared-distance unit. Every pass but
// the last is followed by a centroid update that divides each axis sum of every
// non-empty cluster by its member count in the same divider. A run then delivers K
// summary transfers.
// The block takes no request while a run is in progress.
module kmeans_point_clustering_top (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [1:0] req_action,
   input  logic [9:0] req_point_index,
   input  logic signed [15:0] req_coord_x,
   input  logic signed [15:0] req_coord_y,
   input  logic signed [15:0] req_coord_z,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_kind,
   output logic [3:0] rsp_cluster,
   output logic signed [15:0] rsp_centroid_x,
   output logic signed [15:0] rsp_centroid_y,
   output logic signed [15:0] rsp_centroid_z,
   output logic [10:0] rsp_member_count,
   output logic rsp_last,
   input  logic csr_write,
   input  logic [1:0] csr_index,
   input  logic [10:0] csr_data
);
   import kpc_pkg::*;

   typedef enum logic [13:0] {
      ST_IDLE   = 14'b00000000000001,
      ST_LCLR   = 14'b00000000000010,
      ST_RDWAIT = 14'b00000000000100,
      ST_SWAIT  = 14'b00000000001000,
      ST_SEEDRD = 14'b00000000010000,
      ST_SEEDWR = 14'b00000000100000,
      ST_CLR    = 14'b00000001000000,
      ST_PRD    = 14'b00000010000000,
      ST_PDIST  = 14'b00000100000000,
      ST_PACC   = 14'b00001000000000,
      ST_UPD    = 14'b00010000000000,
      ST_UWAIT  = 14'b00100000000000,
      ST_EMIT   = 14'b01000000000000,
      ST_RSP    = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;
   logic [4:0] k_ff;
   logic [6:0] it_ff;
   logic [10:0] n_ff;

   logic [3*CoordWidth-1:0] pmem [MaxPoints];
   logic [ClIdxW-1:0] lmem [MaxPoints];
   logic [3*CoordWidth-1:0] prd_ff;
   logic [ClIdxW-1:0] lrd_ff;
   logic [PtIdxW-1:0] prd_addr;
   logic lwr;
   logic [ClIdxW-1:0] lwdata;

   logic signed [CoordWidth-1:0] cx_ff [MaxClusters];
   logic signed [CoordWidth-1:0] cy_ff [MaxClusters];
   logic signed [CoordWidth-1:0] cz_ff [MaxClusters];
   logic signed [SumW-1:0] sx_ff [MaxClusters];
   logic signed [SumW-1:0] sy_ff [MaxClusters];
   logic signed [SumW-1:0] sz_ff [MaxClusters];
   logic [CntW-1:0] nc_ff [MaxClusters];

   logic [4:0] kk, ci_ff;
   logic [10:0] nn, pi_ff, step_ff, seed_ff;
   logic [6:0] itr, pass_ff;
   logic [3:0] best_ff;
   logic [DistW-1:0] bd_ff, sqd;
   logic [1:0] ax_ff;
   logic final_ff;

   logic rv_ff, rk_ff, rl_ff;
   logic [3:0] rc_ff;
   logic signed [15:0] rx_ff, ry_ff, rz_ff;
   logic [10:0] rn_ff;

   div_req_type dreq;
   logic dbusy;
   logic signed [CoordWidth-1:0] dq;
   logic req_fire, rsp_fire;

   assign kk  = (k_ff == 5'd0) ? 5'd1 : ((k_ff > 5'd16) ? 5'd16 : k_ff);
   assign nn  = (n_ff > 11'd1024) ? 11'd1024 : n_ff;
   assign itr = (it_ff == 7'd0) ? 7'd1 : it_ff;
   assign req_stall = (state_ff != ST_IDLE) || rv_ff;
   assign req_fire = req_valid && !req_stall;
   assign rsp_fire = rv_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= 5'd4; it_ff <= 7'd10; n_ff <= 11'd1024;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_K:   k_ff <= csr_data[4:0];
            REG_IT:  it_ff <= csr_data[6:0];
            REG_N:   n_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // squared distance of the read point to centroid ci
   logic signed [CoordWidth:0] dx, dy, dz;
   logic [2*CoordWidth+1:0] qx, qy, qz;
   always_comb begin
      dx = (CoordWidth+1)'($signed(prd_ff[47:32])) - (CoordWidth+1)'(cx_ff[ci_ff[3:0]]);
      dy = (CoordWidth+1)'($signed(prd_ff[31:16])) - (CoordWidth+1)'(cy_ff[ci_ff[3:0]]);
      dz = (CoordWidth+1)'($signed(prd_ff[15:0])) - (CoordWidth+1)'(cz_ff[ci_ff[3:0]]);
      qx = $unsigned((2*CoordWidth+2)'(dx) * (2*CoordWidth+2)'(dx));
      qy = $unsigned((2*CoordWidth+2)'(dy) * (2*CoordWidth+2)'(dy));
      qz = $unsigned((2*CoordWidth+2)'(dz) * (2*CoordWidth+2)'(dz));
      sqd = DistW'(qx) + DistW'(qy) + DistW'(qz);
   end

   always_comb begin
      prd_addr = pi_ff[PtIdxW-1:0];
      if (state_ff == ST_IDLE) prd_addr = req_point_index;
      else if (state_ff == ST_SEEDRD) prd_addr = seed_ff[PtIdxW-1:0];
   end
   assign lwr = ((state_ff == ST_PACC) && final_ff) || (state_ff == ST_LCLR);
   assign lwdata = (state_ff == ST_LCLR) ? '0 : best_ff;

   always_ff @(posedge clock) begin
      if (req_fire && req_action == ACT_LOAD)
         pmem[req_point_index] <= {req_coord_x, req_coord_y, req_coord_z};
      prd_ff <= pmem[prd_addr];
      if (lwr) lmem[pi_ff[PtIdxW-1:0]] <= lwdata;
      lrd_ff <= lmem[req_point_index];
   end

   always_comb begin
      state_in = state_ff;
      dreq = '0;
      unique case (state_ff)
         ST_IDLE: if (req_fire) begin
            unique case (req_action)
               ACT_RUN: begin
                  dreq.start = 1'b1;
                  dreq.dividend = SumW'(nn);
                  dreq.divisor = CntW'(kk) + 11'd1;
                  state_in = ST_SWAIT;
               end
               ACT_READ: state_in = ST_RDWAIT;
               default:  state_in = ST_IDLE;
            endcase
         end
         ST_LCLR: state_in = (pi_ff == 11'(MaxPoints - 1)) ? ST_IDLE : ST_LCLR;
         ST_RDWAIT: state_in = ST_IDLE;
         ST_SWAIT: if (!dbusy) state_in = ST_SEEDRD;
         ST_SEEDRD: state_in = ST_SEEDWR;
         ST_SEEDWR: state_in = (ci_ff + 5'd1 == kk) ? ST_CLR : ST_SEEDRD;
         ST_CLR: state_in = (nn == 11'd0) ? (final_ff ? ST_EMIT : ST_UPD) : ST_PRD;
         ST_PRD: state_in = ST_PDIST;
         ST_PDIST: if (ci_ff + 5'd1 >= kk) state_in = ST_PACC;
         ST_PACC: state_in = (pi_ff + 11'd1 == nn) ? (final_ff ? ST_EMIT : ST_UPD) : ST_PRD;
         ST_UPD: begin
            if (ci_ff == kk) state_in = ST_CLR;
            else if (nc_ff[ci_ff[3:0]] != '0) begin
               dreq.start = 1'b1;
               dreq.divisor = nc_ff[ci_ff[3:0]];
               unique case (ax_ff)
                  2'd0:    dreq.dividend = sx_ff[ci_ff[3:0]];
                  2'd1:    dreq.dividend = sy_ff[ci_ff[3:0]];
                  default: dreq.dividend = sz_ff[ci_ff[3:0]];
               endcase
               state_in = ST_UWAIT;
            end
         end
         ST_UWAIT: if (!dbusy) state_in = ST_UPD;
         ST_EMIT: if (!rv_ff || rsp_fire) state_in = (ci_ff + 5'd1 == kk) ? ST_RSP : ST_EMIT;
         ST_RSP: if (!rv_ff || rsp_fire) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   kpc_divider u_div (.clock(clock), .reset(reset), .req(dreq), .busy(dbusy), .quotient(dq));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LCLR; rv_ff <= 1'b0; pi_ff <= '0;
         for (int i = 0; i < MaxClusters; i++) begin
            cx_ff[i] <= '0; cy_ff[i] <= '0; cz_ff[i] <= '0;
            sx_ff[i] <= '0; sy_ff[i] <= '0; sz_ff[i] <= '0; nc_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (rsp_fire && state_ff != ST_EMIT) rv_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (req_fire) begin
               ci_ff <= '0; seed_ff <= '0; pass_ff <= 7'd1; final_ff <= (itr == 7'd1);
            end
            ST_LCLR: pi_ff <= pi_ff + 11'd1;
            ST_RDWAIT: begin
               rv_ff <= 1'b1; rk_ff <= 1'b1; rl_ff <= 1'b1;
               rc_ff <= lrd_ff;
               rx_ff <= '0; ry_ff <= '0; rz_ff <= '0; rn_ff <= '0;
            end
            ST_SWAIT: if (!dbusy) step_ff <= dq[10:0];
            ST_SEEDWR: begin
               cx_ff[ci_ff[3:0]] <= $signed(prd_ff[47:32]);
               cy_ff[ci_ff[3:0]] <= $signed(prd_ff[31:16]);
               cz_ff[ci_ff[3:0]] <= $signed(prd_ff[15:0]);
               ci_ff <= (ci_ff + 5'd1 == kk) ? '0 : ci_ff + 5'd1;
               seed_ff <= seed_ff + step_ff;
            end
            ST_CLR: begin
               pi_ff <= '0; ci_ff <= '0; ax_ff <= '0;
               for (int i = 0; i < MaxClusters; i++) begin
                  sx_ff[i] <= '0; sy_ff[i] <= '0; sz_ff[i] <= '0; nc_ff[i] <= '0;
               end
            end
            ST_PRD: begin
               ci_ff <= '0;
            end
            ST_PDIST: begin
               if (ci_ff == '0 || sqd < bd_ff) begin
                  bd_ff <= sqd; best_ff <= ci_ff[3:0];
               end
               ci_ff <= ci_ff + 5'd1;
            end
            ST_PACC: begin
               sx_ff[best_ff] <= sx_ff[best_ff] + SumW'($signed(prd_ff[47:32]));
               sy_ff[best_ff] <= sy_ff[best_ff] + SumW'($signed(prd_ff[31:16]));
               sz_ff[best_ff] <= sz_ff[best_ff] + SumW'($signed(prd_ff[15:0]));
               nc_ff[best_ff] <= nc_ff[best_ff] + 11'd1;
               pi_ff <= pi_ff + 11'd1;
               ci_ff <= '0;
            end
            ST_UPD: begin
               if (ci_ff == kk) begin
                  ci_ff <= '0; pass_ff <= pass_ff + 7'd1;
                  final_ff <= (pass_ff + 7'd1 == itr);
               end else if (nc_ff[ci_ff[3:0]] == '0) begin
                  ci_ff <= ci_ff + 5'd1; ax_ff <= '0;
               end
            end
            ST_UWAIT: if (!dbusy) begin
               unique case (ax_ff)
                  2'd0:    cx_ff[ci_ff[3:0]] <= dq;
                  2'd1:    cy_ff[ci_ff[3:0]] <= dq;
                  default: cz_ff[ci_ff[3:0]] <= dq;
               endcase
               if (ax_ff == 2'd2) begin
                  ax_ff <= '0; ci_ff <= ci_ff + 5'd1;
               end else ax_ff <= ax_ff + 2'd1;
            end
            ST_EMIT: if (!rv_ff || rsp_fire) begin
               rv_ff <= 1'b1; rk_ff <= 1'b0; rc_ff <= ci_ff[3:0];
               rx_ff <= cx_ff[ci_ff[3:0]]; ry_ff <= cy_ff[ci_ff[3:0]];
               rz_ff <= cz_ff[ci_ff[3:0]]; rn_ff <= nc_ff[ci_ff[3:0]];
               rl_ff <= (ci_ff + 5'd1 == kk);
               ci_ff <= ci_ff + 5'd1;
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_kind = rk_ff;
   assign rsp_cluster = rc_ff;
   assign rsp_centroid_x = rx_ff;
   assign rsp_centroid_y = ry_ff;
   assign rsp_centroid_z = rz_ff;
   assign rsp_member_count = rn_ff;
   assign rsp_last = rl_ff;

`ifndef SYNTHESIS
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall) else $error("request taken while busy");
   a_label_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PACC) |-> (5'(best_ff) < kk)) else $error("label out of range");
   a_div_only_upd: assert property (@(posedge clock) disable iff (reset)
      dreq.start |-> (dreq.divisor != '0)) else $error("divide by zero");
`endif
endmodule

// File: bench/tb_kmeans_point_clustering_top.sv
`timescale 1ns / 1ps
module tb_kmeans_point_clustering_top;
   import kpc_pkg::*;

   typedef struct {
      logic [1:0] action;
      logic [9:0] idx;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } point_req_type;

   typedef struct {
      logic kind;
      logic [3:0] cluster;
      logic signed [15:0] cx;
      logic signed [15:0] cy;
      logic signed [15:0] cz;
      logic [10:0] members;
      logic last;
   } cluster_rsp_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [1:0] req_action = ACT_LOAD;
   logic [9:0] req_point_index = 0;
   logic signed [15:0] req_coord_x = 0;
   logic signed [15:0] req_coord_y = 0;
   logic signed [15:0] req_coord_z = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic rsp_kind;
   logic [3:0] rsp_cluster;
   logic signed [15:0] rsp_centroid_x;
   logic signed [15:0] rsp_centroid_y;
   logic signed [15:0] rsp_centroid_z;
   logic [10:0] rsp_member_count;
   logic rsp_last;
   logic csr_write = 0;
   logic [1:0] csr_index = REG_K;
   logic [10:0] csr_data = 0;

   kmeans_point_clustering_top DUT (.*);

   point_req_type pending_reqs[$];
   cluster_rsp_type expected_rsps[$];
   point_req_type cur_req;
   bit req_taken = 0;
   int burst_left = 0;
   int gap_left = 0;
   bit no_idle = 0;
   int hold_cycles = 0;
   int stall_mode = 0;
   int errors = 0;

   // predictor state
   int pts[MaxPoints][3];
   logic [3:0] labels[MaxPoints];
   int cents[MaxClusters][3];
   longint sums[MaxClusters][3];
   int counts[MaxClusters];
   int k_reg = 4, it_reg = 10, n_reg = 1024;
   // points written so far, tracked when items are generated
   bit gen_written[MaxPoints];
   int gen_n = 1024;

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic longint sq_dist(int p, int c);
      longint acc, d;
      acc = 0;
      for (int a = 0; a < 3; a++) begin
         d = longint'(pts[p][a]) - longint'(cents[c][a]);
         acc += d * d;
      end
      return acc;
   endfunction

   function automatic void assign_points(int k, int n, bit final_pass);
      int best;
      longint bd, d;
      for (int j = 0; j < k; j++) begin
         sums[j] = '{0, 0, 0};
         counts[j] = 0;
      end
      for (int p = 0; p < n; p++) begin
         best = 0;
         bd = sq_dist(p, 0);
         for (int j = 1; j < k; j++) begin
            d = sq_dist(p, j);
            if (d < bd) begin
               bd = d;
               best = j;
            end
         end
         for (int a = 0; a < 3; a++) sums[best][a] += pts[p][a];
         counts[best]++;
         if (final_pass) labels[p] = 4'(best);
      end
   endfunction

   function automatic void cluster_points();
      int k, n, it, step, s;
      cluster_rsp_type r;
      k = (k_reg == 0) ? 1 : (k_reg > MaxClusters ? MaxClusters : k_reg);
      n = (n_reg > MaxPoints) ? MaxPoints : n_reg;
      it = (it_reg == 0) ? 1 : it_reg;
      step = n / (k + 1);
      for (int i = 0; i < k; i++) begin
         s = i * step;
         if (s >= MaxPoints) s = 0;
         cents[i] = pts[s];
      end
      for (int pass = 1; pass < it; pass++) begin
         assign_points(k, n, 0);
         for (int j = 0; j < k; j++)
            if (counts[j] != 0)
               for (int a = 0; a < 3; a++) cents[j][a] = int'(sums[j][a] / counts[j]);
      end
      assign_points(k, n, 1);
      for (int i = 0; i < k; i++) begin
         r.kind = 0;
         r.cluster = 4'(i);
         r.cx = 16'(cents[i][0]);
         r.cy = 16'(cents[i][1]);
         r.cz = 16'(cents[i][2]);
         r.members = 11'(counts[i]);
         r.last = (i == k - 1);
         expected_rsps = {expected_rsps, r};
      end
   endfunction

   function automatic void predict(point_req_type q);
      cluster_rsp_type r;
      case (q.action)
         ACT_LOAD: begin
            pts[q.idx] = '{int'(q.x), int'(q.y), int'(q.z)};
         end
         ACT_READ: begin
            r = '{1'b1, labels[q.idx], 16'sd0, 16'sd0, 16'sd0, 11'd0, 1'b1};
            expected_rsps = {expected_rsps, r};
         end
         ACT_RUN: cluster_points();
         default: ;
      endcase
   endfunction

   // input side: prediction on each accepted transfer
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         predict(cur_req);
         req_taken = 1;
      end
   end

   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         req_taken = 0;
         if (pending_reqs.size() > 0 && (gap_left == 0 || no_idle)) begin
            cur_req = pending_reqs.pop_front();
            req_valid <= 1;
            req_action <= cur_req.action;
            req_point_index <= cur_req.idx;
            req_coord_x <= cur_req.x;
            req_coord_y <= cur_req.y;
            req_coord_z <= cur_req.z;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 0;
            if (gap_left > 0) gap_left--;
         end
      end
   end

   // result side stall pattern, with a long hold when requested
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1;
         hold_cycles--;
      end else begin
         case (stall_mode)
            0: rsp_stall <= 0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 1) == 0);
            default: rsp_stall <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      cluster_rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            report("unexpected transfer, cluster", rsp_cluster, 0);
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_kind !== e.kind) report("kind", rsp_kind, e.kind);
            if (rsp_cluster !== e.cluster) report("cluster", rsp_cluster, e.cluster);
            if (rsp_centroid_x !== e.cx) report("centroid_x", rsp_centroid_x, e.cx);
            if (rsp_centroid_y !== e.cy) report("centroid_y", rsp_centroid_y, e.cy);
            if (rsp_centroid_z !== e.cz) report("centroid_z", rsp_centroid_z, e.cz);
            if (rsp_member_count !== e.members)
               report("member_count", rsp_member_count, e.members);
            if (rsp_last !== e.last) report("last", rsp_last, e.last);
         end
      end
   end

   task automatic wait_idle();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input int value);
      @(negedge clock);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= 11'(value);
      @(negedge clock);
      csr_write <= 0;
      case (idx)
         REG_K: k_reg = value;
         REG_IT: it_reg = value;
         default: begin
            n_reg = value;
            gen_n = (value > MaxPoints) ? MaxPoints : value;
         end
      endcase
   endtask

   task automatic push_req(input logic [1:0] act, input int idx,
                           input int x = 0, input int y = 0, input int z = 0);
      point_req_type q;
      q = '{act, idx[9:0], x[15:0], y[15:0], z[15:0]};
      if (act == ACT_LOAD) gen_written[idx] = 1;
      pending_reqs = {pending_reqs, q};
   endtask

   function automatic bit run_is_safe();
      if (!gen_written[0]) return 0;
      for (int p = 0; p < gen_n; p++)
         if (!gen_written[p]) return 0;
      return 1;
   endfunction

   function automatic int rand_coord();
      case ($urandom_range(0, 5))
         0: return -32768;
         1: return 32767;
         2: return $urandom_range(0, 15) - 8;
         default: return int'($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   task automatic push_random(input int count);
      int r, idx;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 31);
         if (r < 45) push_req(ACT_LOAD, idx, rand_coord(), rand_coord(), rand_coord());
         else if (r < 75) push_req(ACT_READ, idx);
         else if (r < 80) push_req(ACT_IGNORED, idx, rand_coord(), rand_coord(), rand_coord());
         else if (r < 92 && run_is_safe()) push_req(ACT_RUN, idx);
         else push_req(ACT_READ, $urandom_range(0, gen_n > 0 ? gen_n - 1 : 0));
      end
   endtask

   initial begin
      int ex[6][3];
      for (int p = 0; p < MaxPoints; p++) begin
         pts[p] = '{0, 0, 0};
         labels[p] = 0;
         gen_written[p] = 0;
      end
      for (int c = 0; c < MaxClusters; c++) cents[c] = '{0, 0, 0};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: extremes, every action, ignored action, small and zero settings
      write_reg(REG_K, 3);
      write_reg(REG_IT, 2);
      write_reg(REG_N, 6);
      ex = '{'{-32768, -32768, -32768}, '{32767, 32767, 32767}, '{0, 0, 0},
             '{-1, 1, -1}, '{32767, -32768, 0}, '{-32768, 32767, 100}};
      for (int p = 0; p < 6; p++) push_req(ACT_LOAD, p, ex[p][0], ex[p][1], ex[p][2]);
      push_req(ACT_RUN, 0);
      for (int p = 0; p < 6; p++) push_req(ACT_READ, p);
      push_req(ACT_IGNORED, 1023, -1, -1, -1);
      push_req(ACT_READ, 1023);
      wait_idle();
      write_reg(REG_N, 0);
      write_reg(REG_K, 0);
      write_reg(REG_IT, 0);
      push_req(ACT_RUN, 0);
      push_req(ACT_READ, 0);
      wait_idle();
      write_reg(REG_N, 5);
      write_reg(REG_K, 2);
      push_req(ACT_RUN, 0);
      push_req(ACT_READ, 4);
      wait_idle();

      // fill the low part of the store, then a saturated cluster count
      no_idle = 1;
      for (int p = 0; p < 32; p++) push_req(ACT_LOAD, p, rand_coord(), rand_coord(),
                                            rand_coord());
      wait_idle();
      no_idle = 0;
      write_reg(REG_N, 32);
      write_reg(REG_K, 31);
      write_reg(REG_IT, 1);
      push_req(ACT_RUN, 0);
      push_req(ACT_READ, 1023);
      wait_idle();
      write_reg(REG_N, 20);
      write_reg(REG_K, 16);
      write_reg(REG_IT, 64);
      stall_mode = 1;
      push_req(ACT_RUN, 0);
      wait_idle();
      write_reg(REG_N, 4);
      write_reg(REG_K, 1);
      write_reg(REG_IT, 127);
      push_req(ACT_RUN, 0);
      wait_idle();

      // random phases
      for (int ph = 0; ph < 8; ph++) begin
         write_reg(REG_K, ($urandom_range(0, 7) == 0) ? $urandom_range(9, 31)
                                                      : $urandom_range(0, 8));
         write_reg(REG_IT, $urandom_range(0, 5));
         write_reg(REG_N, $urandom_range(0, 24));
         stall_mode = ph % 4;
         no_idle = (ph == 2 || ph == 5);
         if (ph == 4) begin
            hold_cycles = 400;
            for (int i = 0; i < 30; i++) push_req(ACT_READ, $urandom_range(0, 1023));
         end
         push_random(47);
         wait_idle();
      end

      repeat (50) @(posedge clock);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
